[hdl/ddm_pkg.sv]
// Shared constants, types and helpers for the decimal digit mode block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ddm_pkg;

	localparam int DEF_INPUT_BITS = 64;
	localparam int DIGIT_W        = 4;
	localparam int RADIX          = 10;

	// log10(2) scaled by 1e5: decimal digits needed for a given binary width
	function automatic int digits_for(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

	function automatic int max3(input int a, input int b, input int c);
		int m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_PICK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic bin_step;
		logic dig_step;
	} conv_ctrl_t;

	typedef struct packed {
		logic clear;
		logic count_en;
		logic pick_en;
	} hist_ctrl_t;

endpackage

`default_nettype wire

[hdl/ddm_bcd_conv.sv]
// Bit-serial binary to BCD converter (shift and add-3), then digit shift-out.
// Depends on ddm_pkg.
`default_nettype none

module ddm_bcd_conv #(
	parameter int INPUT_BITS = ddm_pkg::DEF_INPUT_BITS,
	parameter int NDIGITS    = ddm_pkg::digits_for(ddm_pkg::DEF_INPUT_BITS)
) (
	input  wire logic                         clk,
	input  wire ddm_pkg::conv_ctrl_t          ctrl,
	input  wire logic [INPUT_BITS-1:0]        number,
	output logic [ddm_pkg::DIGIT_W-1:0]       top_digit
);
	import ddm_pkg::*;

	localparam int BCD_W = NDIGITS * DIGIT_W;

	logic [INPUT_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;

	always_comb begin
		for (int i = 0; i < NDIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= number;
			bcd_q <= '0;
		end else if (ctrl.bin_step) begin
			bin_q <= {bin_q[INPUT_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[INPUT_BITS-1]};
		end else if (ctrl.dig_step) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];

endmodule

`default_nettype wire

[hdl/ddm_hist.sv]
// Digit histogram: counts significant digits, then rotates the counters
// past one comparator to pick the most frequent digit. Depends on ddm_pkg.
`default_nettype none

module ddm_hist #(
	parameter int NDIGITS = ddm_pkg::digits_for(ddm_pkg::DEF_INPUT_BITS)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ddm_pkg::hist_ctrl_t          ctrl,
	input  wire logic [ddm_pkg::DIGIT_W-1:0]  digit,
	output logic [ddm_pkg::DIGIT_W-1:0]       best_digit
);
	import ddm_pkg::*;

	localparam int CW = $clog2(NDIGITS + 1);

	logic [CW-1:0]      counts_q [RADIX];
	logic [CW-1:0]      best_count_q;
	logic [DIGIT_W-1:0] best_digit_q;
	logic [DIGIT_W-1:0] idx_q;
	logic               started_q;
	logic               hit;

	assign hit = started_q || (digit != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			idx_q     <= '0;
		end else if (ctrl.clear) begin
			started_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (ctrl.count_en && digit != '0) started_q <= 1'b1;
			if (ctrl.pick_en) idx_q <= idx_q + DIGIT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			for (int i = 0; i < RADIX; i++) counts_q[i] <= '0;
		end else if (ctrl.count_en && hit) begin
			for (int i = 0; i < RADIX; i++) begin
				if (digit == DIGIT_W'(i)) counts_q[i] <= counts_q[i] + CW'(1);
			end
		end else if (ctrl.pick_en) begin
			for (int i = 0; i < RADIX - 1; i++) counts_q[i] <= counts_q[i+1];
			counts_q[RADIX-1] <= counts_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pick_en && (idx_q == '0 || counts_q[0] > best_count_q)) begin
			best_count_q <= counts_q[0];
			best_digit_q <= idx_q;
		end
	end

	assign best_digit = best_digit_q;

endmodule

`default_nettype wire

[hdl/decimal_digit_mode_top.sv]
// Most frequent decimal digit of an unsigned number: top level with control.
// Depends on ddm_pkg, ddm_bcd_conv and ddm_hist.
//
// Each request takes a load step, then goes one bit per cycle through the
// shift-and-add-3 converter, one decimal digit per cycle (NDIGITS = 20 at 64
// bits) into the histogram and one counter per cycle through the compare,
// and then posts the result. The result sits in an output register, so the
// next request is taken while it waits.
`default_nettype none

module decimal_digit_mode_top #(
	parameter int INPUT_BITS = ddm_pkg::DEF_INPUT_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         number_valid,
	output logic                              number_stall,
	input  wire logic [INPUT_BITS-1:0]        number,
	output logic                              mode_valid,
	input  wire logic                         mode_stall,
	output logic [ddm_pkg::DIGIT_W-1:0]       mode_digit
);
	import ddm_pkg::*;

	localparam int NDIGITS = digits_for(INPUT_BITS);
	localparam int CNT_MAX = max3(INPUT_BITS, NDIGITS, RADIX);
	localparam int CNT_W   = $clog2(CNT_MAX);

	state_t             state_q, state_nxt;
	logic [CNT_W-1:0]   cnt_q;
	logic               cnt_last;
	logic               out_free;
	logic               out_load;
	logic               mode_valid_q;
	logic [DIGIT_W-1:0] mode_digit_q;
	logic [DIGIT_W-1:0] top_digit;
	logic [DIGIT_W-1:0] best_digit;
	conv_ctrl_t         conv_ctrl;
	hist_ctrl_t         hist_ctrl;

	assign out_free = !mode_valid_q || !mode_stall;

	always_comb begin
		unique case (state_q)
			ST_CONV: cnt_last = (cnt_q == CNT_W'(INPUT_BITS - 1));
			ST_SCAN: cnt_last = (cnt_q == CNT_W'(NDIGITS - 1));
			ST_PICK: cnt_last = (cnt_q == CNT_W'(RADIX - 1));
			default: cnt_last = 1'b0;
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (number_valid) state_nxt = ST_CONV;
			ST_CONV: if (cnt_last) state_nxt = ST_SCAN;
			ST_SCAN: if (cnt_last) state_nxt = ST_PICK;
			ST_PICK: if (cnt_last) state_nxt = ST_DONE;
			ST_DONE: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		conv_ctrl    = '0;
		hist_ctrl    = '0;
		out_load     = 1'b0;
		number_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				number_stall    = 1'b0;
				conv_ctrl.load  = number_valid;
				hist_ctrl.clear = number_valid;
			end
			ST_CONV: conv_ctrl.bin_step = 1'b1;
			ST_SCAN: begin
				conv_ctrl.dig_step = 1'b1;
				hist_ctrl.count_en = 1'b1;
			end
			ST_PICK: hist_ctrl.pick_en = 1'b1;
			ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			mode_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q != state_nxt) cnt_q <= '0;
			else if (state_q != ST_IDLE && state_q != ST_DONE) cnt_q <= cnt_q + CNT_W'(1);
			if (out_load) mode_valid_q <= 1'b1;
			else if (!mode_stall) mode_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) mode_digit_q <= best_digit;
	end

	ddm_bcd_conv #(
		.INPUT_BITS(INPUT_BITS),
		.NDIGITS   (NDIGITS)
	) u_conv (
		.clk      (clk),
		.ctrl     (conv_ctrl),
		.number   (number),
		.top_digit(top_digit)
	);

	ddm_hist #(
		.NDIGITS(NDIGITS)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (hist_ctrl),
		.digit     (top_digit),
		.best_digit(best_digit)
	);

	assign mode_valid = mode_valid_q;
	assign mode_digit = mode_digit_q;

endmodule

`default_nettype wire
